### hw/rtl/line_prefix_bucket_splitter_defines.svh
// assertion helpers used by line_prefix_bucket_splitter.sv
`ifndef LINE_PREFIX_BUCKET_SPLITTER_DEFINES_SVH
`define LINE_PREFIX_BUCKET_SPLITTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LPBS_ASSERT_NOW(label, cond, check) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, checked outside reset
`define LPBS_ASSERT_NEXT(label, cond, check) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error("assertion failed: next-cycle check");

`endif

### hw/rtl/lpbs_pkg.sv
package lpbs_pkg;

    localparam int COUNT_WIDTH    = 32;
    localparam int POSITION_WIDTH = 32;

    localparam int LETTERS   = 26;
    localparam int PAIRS     = LETTERS * LETTERS;
    localparam int TRIPLES   = PAIRS * LETTERS;
    // pair counts first, single-letter counts after them
    localparam int MEM_DEPTH = PAIRS + LETTERS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int MODE_W   = 2;
    localparam int KIND_W   = 3;
    localparam int BUCKET_W = 15;
    localparam int INDEX_W  = 10;

    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RD_1  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RD_2  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PAIR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LONG   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAD    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

    localparam logic [7:0] CHAR_NL = 8'h0a;
    localparam logic [7:0] CHAR_A  = 8'h61;
    localparam logic [7:0] CHAR_Z  = 8'h7a;

    typedef logic [COUNT_WIDTH-1:0]    count_t;
    typedef logic [POSITION_WIDTH-1:0] position_t;
    typedef logic [MEM_AW-1:0]         mem_addr_t;

    // work carried from the memory read to the output register
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BUCKET_W-1:0] bucket;
        position_t           suffix;
        mem_addr_t           addr;
        logic                use_mem;
        logic                inc;
    } stage_t;

endpackage

### hw/rtl/line_prefix_bucket_splitter.sv
// line_prefix_bucket_splitter
// input channel (in_valid/in_ready): one text byte with its buffer position, or a
// count read request (mode 1 single letter, mode 2 letter pair).
// output channel (out_valid/out_ready): at most one result per input transfer:
// a single or pair line with its updated count, a long line with its three-letter
// bucket and suffix position, a flag for empty or bad lines, or a read count.
// text bytes inside a line, and items in mode 3, give no result.
// throughput: one input transfer per cycle while the output does not stall and no
// clear sweep runs, set by the single count memory with one read port and one write
// port; the count is read when the newline is taken and written back as the item
// leaves the read stage, with a bypass for back-to-back hits.
// each result passes the read stage and then the output register on its way out.
// reset: line state clears at once; the count memory is then swept to zero entry
// by entry, during which in_ready stays low.
// stall: the output register holds its result while out_ready is low; one item
// waits behind it in the read stage, after which in_ready drops.
`include "line_prefix_bucket_splitter_defines.svh"

module line_prefix_bucket_splitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    text_byte,
    input  logic [31:0]                   byte_position,
    input  logic                          chunk_end,
    input  logic [9:0]                    read_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    line_kind,
    output logic [14:0]                   bucket_index,
    output logic [lpbs_pkg::COUNT_WIDTH-1:0]    count_value,
    output logic [lpbs_pkg::POSITION_WIDTH-1:0] suffix_position
);
    import lpbs_pkg::*;

    // line state
    position_t           line_start_reg, line_start_next;
    logic [1:0]          chars_seen_reg, chars_seen_next;
    logic [BUCKET_W-1:0] prefix_reg, prefix_next;
    logic                bad_seen_reg, bad_seen_next;

    // count memory and its clear sweep
    count_t    mem [MEM_DEPTH];
    count_t    rd_data_reg;
    logic      clearing_reg;
    mem_addr_t clr_addr_reg;

    logic      wr_en;
    mem_addr_t wr_addr;
    count_t    wr_data;
    logic      fwd_valid_reg;
    mem_addr_t fwd_addr_reg;
    count_t    fwd_data_reg;

    // read stage and output register
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;
    logic   s1_load;
    logic   s1_advance;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    count_t              count_reg;
    position_t           suffix_reg;

    logic   in_fire;
    logic   is_letter;
    logic   is_nl;
    count_t cur_count;
    count_t inc_count;
    count_t s1_count;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !clearing_reg && (!s1_valid_reg || s1_advance);
    assign in_fire    = in_valid && in_ready;
    assign is_letter  = (text_byte >= CHAR_A) && (text_byte <= CHAR_Z);
    assign is_nl      = (text_byte == CHAR_NL);

    // decode the incoming item: line state update and read-stage work
    always_comb
    begin
        line_start_next = line_start_reg;
        chars_seen_next = chars_seen_reg;
        prefix_next     = prefix_reg;
        bad_seen_next   = bad_seen_reg;
        s1_load         = 1'b0;
        s1_next.kind    = KIND_READ;
        s1_next.bucket  = '0;
        s1_next.suffix  = '0;
        s1_next.addr    = '0;
        s1_next.use_mem = 1'b0;
        s1_next.inc     = 1'b0;
        unique case (mode)
            MODE_RD_1:
            begin
                s1_load        = 1'b1;
                s1_next.bucket = BUCKET_W'(read_index);
                if (read_index < INDEX_W'(LETTERS))
                begin
                    s1_next.use_mem = 1'b1;
                    s1_next.addr    = MEM_AW'(PAIRS) + MEM_AW'(read_index);
                end
            end
            MODE_RD_2:
            begin
                s1_load        = 1'b1;
                s1_next.bucket = BUCKET_W'(read_index);
                if (read_index < INDEX_W'(PAIRS))
                begin
                    s1_next.use_mem = 1'b1;
                    s1_next.addr    = MEM_AW'(read_index);
                end
            end
            MODE_TEXT:
            begin
                if (is_nl)
                begin
                    s1_load         = 1'b1;
                    line_start_next = '0;
                    chars_seen_next = '0;
                    prefix_next     = '0;
                    bad_seen_next   = 1'b0;
                    if (chars_seen_reg == 2'd0)
                        s1_next.kind = KIND_EMPTY;
                    else if (bad_seen_reg)
                        s1_next.kind = KIND_BAD;
                    else if (chars_seen_reg == 2'd1)
                    begin
                        s1_next.kind    = KIND_SINGLE;
                        s1_next.bucket  = prefix_reg;
                        s1_next.addr    = MEM_AW'(PAIRS) + MEM_AW'(prefix_reg);
                        s1_next.use_mem = 1'b1;
                        s1_next.inc     = 1'b1;
                    end
                    else if (chars_seen_reg == 2'd2)
                    begin
                        s1_next.kind    = KIND_PAIR;
                        s1_next.bucket  = prefix_reg;
                        s1_next.addr    = MEM_AW'(prefix_reg);
                        s1_next.use_mem = 1'b1;
                        s1_next.inc     = 1'b1;
                    end
                    else
                    begin
                        s1_next.kind   = KIND_LONG;
                        s1_next.bucket = prefix_reg;
                        s1_next.suffix = line_start_reg + POSITION_WIDTH'(3);
                    end
                end
                else if (chunk_end)
                begin
                    // unfinished line is dropped
                    line_start_next = '0;
                    chars_seen_next = '0;
                    prefix_next     = '0;
                    bad_seen_next   = 1'b0;
                end
                else
                begin
                    if (chars_seen_reg == 2'd0)
                        line_start_next = POSITION_WIDTH'(byte_position);
                    if (!is_letter)
                        bad_seen_next = 1'b1;
                    else if (chars_seen_reg != 2'd3)
                        // prefix stays below 676 here, so no wrap is possible
                        prefix_next = BUCKET_W'(prefix_reg * BUCKET_W'(LETTERS)
                                      + BUCKET_W'(text_byte - CHAR_A));
                    if (chars_seen_reg != 2'd3)
                        chars_seen_next = chars_seen_reg + 2'd1;
                end
            end
            MODE_NONE:
            begin
                s1_load = 1'b0;
            end
            default:
            begin
                s1_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= '0;
            chars_seen_reg <= '0;
            prefix_reg     <= '0;
            bad_seen_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            line_start_reg <= line_start_next;
            chars_seen_reg <= chars_seen_next;
            prefix_reg     <= prefix_next;
            bad_seen_reg   <= bad_seen_next;
        end
    end

    // count memory: one synchronous read, one write
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_data_reg <= mem[s1_next.addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // bypass the write that landed in the same cycle as the read
    assign cur_count = (fwd_valid_reg && fwd_addr_reg == s1_reg.addr) ? fwd_data_reg
                                                                       : rd_data_reg;
    assign inc_count = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);
    assign s1_count  = !s1_reg.use_mem ? '0 : (s1_reg.inc ? inc_count : cur_count);

    assign wr_en   = clearing_reg || (s1_advance && s1_reg.inc);
    assign wr_addr = clearing_reg ? clr_addr_reg : s1_reg.addr;
    assign wr_data = clearing_reg ? '0 : inc_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_addr_reg == MEM_AW'(MEM_DEPTH - 1))
                    clearing_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + MEM_AW'(1);
            end
            if (clearing_reg)
                fwd_valid_reg <= 1'b0;
            else if (wr_en)
                fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= s1_load;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= s1_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            kind_reg   <= s1_reg.kind;
            bucket_reg <= s1_reg.bucket;
            count_reg  <= s1_count;
            suffix_reg <= s1_reg.suffix;
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_kind       = kind_reg;
    assign bucket_index    = bucket_reg;
    assign count_value     = count_reg;
    assign suffix_position = suffix_reg;

    `LPBS_ASSERT_NOW(a_no_take_while_clearing, clearing_reg, !in_ready)
    `LPBS_ASSERT_NOW(a_count_never_wraps, wr_en && !clearing_reg, wr_data != '0)
    `LPBS_ASSERT_NOW(a_inc_only_on_counted_lines, s1_valid_reg && s1_reg.inc,
        s1_reg.kind == KIND_SINGLE || s1_reg.kind == KIND_PAIR)
    `LPBS_ASSERT_NEXT(a_text_byte_no_result,
        in_fire && mode == MODE_TEXT && !is_nl, !s1_valid_reg)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lpbs_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 31;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [7:0]         tbyte;
        position_t          pos;
        logic               ce;
        logic [INDEX_W-1:0] ridx;
    } text_item_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [BUCKET_W-1:0] bucket;
        count_t              count;
        position_t           suffix;
    } line_result_t;

    typedef struct {
        text_item_t   item;
        bit           known;
        line_result_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MODE_W-1:0]     mode = MODE_TEXT;
    logic [7:0]            text_byte = '0;
    logic [31:0]           byte_position = '0;
    logic                  chunk_end = 1'b0;
    logic [INDEX_W-1:0]    read_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [KIND_W-1:0]     line_kind;
    logic [BUCKET_W-1:0]   bucket_index;
    count_t                count_value;
    position_t             suffix_position;

    // open line and count stores as the block should hold them
    position_t             ln_start = '0;
    logic [1:0]            ln_chars = '0;
    logic [BUCKET_W-1:0]   ln_prefix = '0;
    logic                  ln_bad = 1'b0;
    logic                  ln_open = 1'b0;
    count_t                letter_tally [LETTERS] = '{default: '0};
    count_t                pair_tally [PAIRS] = '{default: '0};

    stim_row_t             dir_rows [$];
    line_result_t          pending_results [$];
    bit                    idle_on = 1'b1;
    int                    fail_count = 0;
    int                    transfers_in = 0;
    int                    results_checked = 0;
    int                    kind_seen [8] = '{default: 0};
    int                    cycle_count = 0;

    line_prefix_bucket_splitter u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .text_byte       (text_byte),
        .byte_position   (byte_position),
        .chunk_end       (chunk_end),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .line_kind       (line_kind),
        .bucket_index    (bucket_index),
        .count_value     (count_value),
        .suffix_position (suffix_position)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic stim_row_t make_row(
        input logic [MODE_W-1:0]   m,
        input logic [7:0]          b,
        input position_t           p,
        input logic                ce,
        input logic [INDEX_W-1:0]  ri,
        input bit                  known = 1'b0,
        input logic [KIND_W-1:0]   k = KIND_SINGLE,
        input logic [BUCKET_W-1:0] bk = '0,
        input count_t              c = '0,
        input position_t           s = '0
    );
        stim_row_t row;
        row.item.mode  = m;
        row.item.tbyte = b;
        row.item.pos   = p;
        row.item.ce    = ce;
        row.item.ridx  = ri;
        row.known       = known;
        row.want.kind   = k;
        row.want.bucket = bk;
        row.want.count  = c;
        row.want.suffix = s;
        return row;
    endfunction

    function automatic void add_row(input stim_row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void queue_result(input line_result_t r);
        pending_results = {pending_results, r};
    endfunction

    function automatic void close_line();
        ln_start  = '0;
        ln_chars  = '0;
        ln_prefix = '0;
        ln_bad    = 1'b0;
        ln_open   = 1'b0;
    endfunction

    // advances the line state by one transfer, returns 1 when a result is due
    function automatic bit predict_line_result(input text_item_t it, output line_result_t res);
        int unsigned idx;
        res.kind   = KIND_SINGLE;
        res.bucket = '0;
        res.count  = '0;
        res.suffix = '0;
        case (it.mode)
            MODE_RD_1:
            begin
                res.kind   = KIND_READ;
                res.bucket = BUCKET_W'(it.ridx);
                if (it.ridx < LETTERS)
                    res.count = letter_tally[it.ridx];
                return 1'b1;
            end
            MODE_RD_2:
            begin
                res.kind   = KIND_READ;
                res.bucket = BUCKET_W'(it.ridx);
                if (it.ridx < PAIRS)
                    res.count = pair_tally[it.ridx];
                return 1'b1;
            end
            MODE_NONE:
                return 1'b0;
            default:
                ;
        endcase

        if (it.tbyte == CHAR_NL)
        begin
            if (!ln_open || ln_chars == 0)
                res.kind = KIND_EMPTY;
            else if (ln_bad)
                res.kind = KIND_BAD;
            else if (ln_chars == 1)
            begin
                idx = ln_prefix % LETTERS;
                if (~&letter_tally[idx])
                    letter_tally[idx]++;
                res.kind   = KIND_SINGLE;
                res.bucket = BUCKET_W'(idx);
                res.count  = letter_tally[idx];
            end
            else if (ln_chars == 2)
            begin
                idx = ln_prefix % PAIRS;
                if (~&pair_tally[idx])
                    pair_tally[idx]++;
                res.kind   = KIND_PAIR;
                res.bucket = BUCKET_W'(idx);
                res.count  = pair_tally[idx];
            end
            else
            begin
                res.kind   = KIND_LONG;
                res.bucket = ln_prefix;
                res.suffix = ln_start + 32'd3;
            end
            close_line();
            return 1'b1;
        end

        if (!ln_open)
        begin
            ln_open  = 1'b1;
            ln_start = it.pos;
        end
        if (it.tbyte < CHAR_A || it.tbyte > CHAR_Z)
            ln_bad = 1'b1;
        else if (ln_chars < 3)
            ln_prefix = BUCKET_W'((ln_prefix * LETTERS + (it.tbyte - CHAR_A)) % TRIPLES);
        if (ln_chars < 3)
            ln_chars++;
        if (it.ce)
            close_line();
        return 1'b0;
    endfunction

    task automatic send_item(input stim_row_t row);
        line_result_t res;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= row.item.mode;
        text_byte     <= row.item.tbyte;
        byte_position <= row.item.pos;
        chunk_end     <= row.item.ce;
        read_index    <= row.item.ridx;
        do
            @(posedge clk);
        while (!in_ready);
        transfers_in++;
        if (predict_line_result(row.item, res))
            queue_result(row.known ? row.want : res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // result side: random back-pressure and in-order compare
    always @(posedge clk)
    begin : result_check
        line_result_t want;
        out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: line_kind %0d bucket_index %0d", line_kind,
                       bucket_index);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                kind_seen[want.kind]++;
                if (line_kind !== want.kind)
                begin
                    $error("line_kind mismatch: expected %0d, got %0d", want.kind, line_kind);
                    fail_count++;
                end
                if (bucket_index !== want.bucket)
                begin
                    $error("bucket_index mismatch: expected %0d, got %0d", want.bucket,
                           bucket_index);
                    fail_count++;
                end
                if (count_value !== want.count)
                begin
                    $error("count_value mismatch: expected %0d, got %0d", want.count,
                           count_value);
                    fail_count++;
                end
                if (suffix_position !== want.suffix)
                begin
                    $error("suffix_position mismatch: expected 0x%08h, got 0x%08h",
                           want.suffix, suffix_position);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        position_t   cursor;
        int          pick;
        int          len;
        int          bad_at;
        int          random_sent;
        bit          narrow;
        bit          paused_mid;
        logic [7:0]  b;
        logic [MODE_W-1:0] rd_mode;
        logic [INDEX_W-1:0] rd_idx;

        random_sent = 0;
        paused_mid  = 1'b0;

        // reads straight after reset, including indexes past the stores
        add_row(make_row(MODE_RD_1, 8'h00, 32'h0, 1'b0, 10'd0,
                         1'b1, KIND_READ, 15'd0, '0, '0));
        add_row(make_row(MODE_RD_2, 8'hff, 32'hffff_ffff, 1'b1, 10'd675,
                         1'b1, KIND_READ, 15'd675, '0, '0));
        add_row(make_row(MODE_RD_1, 8'h00, 32'h0, 1'b0, 10'd1023,
                         1'b1, KIND_READ, 15'd1023, '0, '0));
        add_row(make_row(MODE_RD_2, 8'h00, 32'h0, 1'b0, 10'd676,
                         1'b1, KIND_READ, 15'd676, '0, '0));
        // empty line
        add_row(make_row(MODE_TEXT, CHAR_NL, 32'h0, 1'b0, 10'd0,
                         1'b1, KIND_EMPTY, '0, '0, '0));
        // single letter, newline also flagged as chunk end
        add_row(make_row(MODE_TEXT, CHAR_A, 32'h10, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_NL, 32'h11, 1'b1, 10'd0,
                         1'b1, KIND_SINGLE, 15'd0, 32'd1, '0));
        // highest pair
        add_row(make_row(MODE_TEXT, CHAR_Z, 32'h20, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_Z, 32'h21, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_NL, 32'h22, 1'b0, 10'd0,
                         1'b1, KIND_PAIR, 15'd675, 32'd1, '0));
        // long line whose suffix position wraps past the top of the buffer
        add_row(make_row(MODE_TEXT, CHAR_A, 32'hffff_fffe, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_A + 8'd1, 32'hffff_ffff, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_A + 8'd2, 32'h0, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_Z, 32'h1, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_NL, 32'h2, 1'b0, 10'd0,
                         1'b1, KIND_LONG, 15'd28, '0, 32'd1));
        // byte outside the letters
        add_row(make_row(MODE_TEXT, 8'h00, 32'h40, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_NL, 32'h41, 1'b0, 10'd0,
                         1'b1, KIND_BAD, '0, '0, '0));
        // unfinished line dropped at chunk end, so the newline sees an empty line
        add_row(make_row(MODE_TEXT, CHAR_A + 8'd16, 32'h50, 1'b1, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_NL, 32'h51, 1'b0, 10'd0,
                         1'b1, KIND_EMPTY, '0, '0, '0));
        // unused mode in the middle of a line is ignored
        add_row(make_row(MODE_TEXT, CHAR_Z, 32'h60, 1'b0, 10'd0));
        add_row(make_row(MODE_NONE, 8'hff, 32'hffff_ffff, 1'b1, 10'd1023));
        add_row(make_row(MODE_TEXT, 8'hff, 32'h61, 1'b0, 10'd0));
        add_row(make_row(MODE_TEXT, CHAR_NL, 32'h62, 1'b0, 10'd0,
                         1'b1, KIND_BAD, '0, '0, '0));
        add_row(make_row(MODE_RD_1, 8'h00, 32'h0, 1'b0, 10'd0));
        add_row(make_row(MODE_RD_2, 8'h00, 32'h0, 1'b0, 10'd675));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        wait_drained();

        while (random_sent < RANDOM_ITEMS)
        begin
            idle_on = !(random_sent >= 150 && random_sent < 300);
            if (!paused_mid && random_sent >= 400)
            begin
                wait_drained();
                paused_mid = 1'b1;
            end
            pick   = $urandom_range(99);
            cursor = ($urandom_range(9) == 0) ? 32'hffff_fffc + $urandom_range(3) : $urandom;
            if (pick < 62)
            begin
                // clean line; a narrow alphabet makes counts repeat
                len    = $urandom_range(5);
                narrow = $urandom_range(1);
                for (int k = 0; k < len; k++)
                begin
                    b = CHAR_A + 8'(narrow ? $urandom_range(2) : $urandom_range(25));
                    send_item(make_row(MODE_TEXT, b, cursor + k, 1'b0, 10'($urandom)));
                    random_sent++;
                end
                send_item(make_row(MODE_TEXT, CHAR_NL, cursor + len, 1'($urandom),
                                   10'($urandom)));
                random_sent++;
            end
            else if (pick < 76)
            begin
                rd_mode = $urandom_range(1) ? MODE_RD_1 : MODE_RD_2;
                if ($urandom_range(3) == 0)
                    rd_idx = 10'($urandom);
                else if (rd_mode == MODE_RD_1)
                    rd_idx = 10'($urandom_range(LETTERS - 1));
                else
                    rd_idx = 10'($urandom_range(PAIRS - 1));
                send_item(make_row(rd_mode, 8'($urandom), $urandom, 1'($urandom), rd_idx));
                random_sent++;
            end
            else if (pick < 88)
            begin
                // one byte outside the letters somewhere in the line
                len    = $urandom_range(1, 5);
                bad_at = $urandom_range(len - 1);
                for (int k = 0; k < len; k++)
                begin
                    if (k == bad_at)
                    begin
                        do
                            b = 8'($urandom);
                        while (b == CHAR_NL || (b >= CHAR_A && b <= CHAR_Z));
                    end
                    else
                        b = CHAR_A + 8'($urandom_range(25));
                    send_item(make_row(MODE_TEXT, b, cursor + k, 1'b0, 10'($urandom)));
                    random_sent++;
                end
                send_item(make_row(MODE_TEXT, CHAR_NL, cursor + len, 1'b0, 10'($urandom)));
                random_sent++;
            end
            else if (pick < 95)
            begin
                // line cut off by chunk end, no result
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                begin
                    b = CHAR_A + 8'($urandom_range(25));
                    send_item(make_row(MODE_TEXT, b, cursor + k, 1'(k == len - 1),
                                       10'($urandom)));
                    random_sent++;
                end
            end
            else
            begin
                send_item(make_row(MODE_NONE, 8'($urandom), $urandom, 1'($urandom),
                                   10'($urandom)));
                random_sent++;
            end
        end

        idle_on = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d input transfers, %0d results checked", transfers_in, results_checked);
        $display("results by kind: single %0d, pair %0d, long %0d, empty %0d, bad %0d, read %0d",
                 kind_seen[KIND_SINGLE], kind_seen[KIND_PAIR], kind_seen[KIND_LONG],
                 kind_seen[KIND_EMPTY], kind_seen[KIND_BAD], kind_seen[KIND_READ]);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lpbs_pkg.sv
hw/rtl/line_prefix_bucket_splitter.sv
tb/tb_top.sv
